// ===== hdl/tsd_pkg.sv =====
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared types and constants of the tick supervisor: transaction payloads,
// configuration register file layout, register indexes and radar states.
// ----------------------------------------------------------------------------
package tsd_pkg;

	// configuration registers are all this wide
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 3;
	localparam int HORN_W    = 8;

	// register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLINK_PERIOD      = 3'd0,
		REG_HORN_ON_TICKS     = 3'd1,
		REG_HORN_PERIOD_TICKS = 3'd2,
		REG_LINK_TIMEOUT      = 3'd3,
		REG_RADAR_DEBOUNCE    = 3'd4
	} tsd_reg_idx_t;

	// reset values of the registers
	localparam logic [CFG_W-1:0] RST_BLINK_PERIOD      = 8'd5;
	localparam logic [CFG_W-1:0] RST_HORN_ON_TICKS     = 8'd2;
	localparam logic [CFG_W-1:0] RST_HORN_PERIOD_TICKS = 8'd4;
	localparam logic [CFG_W-1:0] RST_LINK_TIMEOUT      = 8'd20;
	localparam logic [CFG_W-1:0] RST_RADAR_DEBOUNCE    = 8'd3;

	typedef struct packed {
		logic [CFG_W-1:0] blink_period;
		logic [CFG_W-1:0] horn_on_ticks;
		logic [CFG_W-1:0] horn_period_ticks;
		logic [CFG_W-1:0] link_timeout;
		logic [CFG_W-1:0] radar_debounce;
	} tsd_cfg_t;

	// one main-loop pass
	typedef struct packed {
		logic              tick;
		logic              radar_detected;
		logic              com_received;
		logic              horn_load;
		logic [HORN_W-1:0] horn_count;
	} tsd_in_t;

	// status after one pass
	typedef struct packed {
		logic led;
		logic horn;
		logic stop_request;
		logic link_active;
	} tsd_out_t;

	typedef enum logic {
		RADAR_IDLE     = 1'b0,
		RADAR_STOPPING = 1'b1
	} tsd_radar_state_t;

endpackage

// ===== hdl/tick_supervisor_with_debounce_unit.sv =====
// ----------------------------------------------------------------------------
// tick_supervisor_with_debounce_unit
// Main-loop supervisor: led blink, horn beeps, host link watchdog and rear
// radar debounce, one result transaction for every pass transaction.
// ----------------------------------------------------------------------------
// Each item transaction is one main-loop pass and yields exactly one result
// transaction. A pass is captured in an input register and its whole update
// is computed combinationally into the result register, from which the result
// is offered; while the result side is not stalled a new pass is taken in every
// cycle, a sustained rate of one pass per clock. item_stall rises only when the
// input register is full and the result register is full and stalled; a
// waiting result blocks new passes only once the input register also holds one.
// Configuration registers are written through cfg_* (cfg_ready is
// always high) and should only be changed while no pass is in flight.
// COUNT_WIDTH sets the width of the led, horn phase, link and radar counters.
module tick_supervisor_with_debounce_unit #(
	parameter int COUNT_WIDTH = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// pass channel
	input  logic                           item_valid,
	output logic                           item_stall,
	input  tsd_pkg::tsd_in_t               item,
	// result channel
	output logic                           result_valid,
	input  logic                           result_stall,
	output tsd_pkg::tsd_out_t              result,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tsd_pkg::CFG_W-1:0]      cfg_data
);
	import tsd_pkg::*;

	tsd_cfg_t cfg_q;

	// input register
	tsd_in_t  item_s1;
	logic     item_valid_s1;

	// result register
	tsd_out_t result_s2;
	logic     result_valid_s2;

	tsd_out_t core_result;
	logic     item_take;
	logic     s1_go;
	logic     result_free;

	// the result register can load when empty or being emptied this cycle
	assign result_free = !result_valid_s2 || !result_stall;
	assign s1_go       = item_valid_s1 && result_free;

	// the input register holds only while its pass cannot move on
	assign item_stall  = item_valid_s1 && !result_free;
	assign item_take   = item_valid && !item_stall;

	assign cfg_ready   = 1'b1;

	// register file writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blink_period      <= RST_BLINK_PERIOD;
			cfg_q.horn_on_ticks     <= RST_HORN_ON_TICKS;
			cfg_q.horn_period_ticks <= RST_HORN_PERIOD_TICKS;
			cfg_q.link_timeout      <= RST_LINK_TIMEOUT;
			cfg_q.radar_debounce    <= RST_RADAR_DEBOUNCE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BLINK_PERIOD:      cfg_q.blink_period      <= cfg_data;
				REG_HORN_ON_TICKS:     cfg_q.horn_on_ticks     <= cfg_data;
				REG_HORN_PERIOD_TICKS: cfg_q.horn_period_ticks <= cfg_data;
				REG_LINK_TIMEOUT:      cfg_q.link_timeout      <= cfg_data;
				REG_RADAR_DEBOUNCE:    cfg_q.radar_debounce    <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			item_valid_s1 <= item_valid;
		end
	end

	// input stage payload, loads with every taken pass
	always_ff @(posedge clk) begin
		if (item_take) begin
			item_s1 <= item;
		end
	end

	// supervisor state and single-pass update
	tsd_core #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (s1_go),
		.cfg    (cfg_q),
		.item   (item_s1),
		.result (core_result)
	);

	// result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (result_free) begin
			result_valid_s2 <= item_valid_s1;
		end
	end

	// result stage payload
	always_ff @(posedge clk) begin
		if (s1_go) begin
			result_s2 <= core_result;
		end
	end

	assign result_valid = result_valid_s2;
	assign result       = result_s2;

endmodule

// ===== hdl/tsd_core.sv =====
// ----------------------------------------------------------------------------
// tsd_core
// Supervisor state and its single-pass update: led blinker, horn beep
// sequencer, host link watchdog and radar debounce machine.
// ----------------------------------------------------------------------------
module tsd_core #(
	parameter int COUNT_WIDTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  tsd_pkg::tsd_cfg_t cfg,
	input  tsd_pkg::tsd_in_t  item,
	output tsd_pkg::tsd_out_t result
);
	import tsd_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	logic [COUNT_WIDTH-1:0] led_count_q, led_count_d, led_inc;
	logic                   led_level_q, led_level_d;
	logic [HORN_W-1:0]      horn_remaining_q, horn_remaining_d;
	logic [COUNT_WIDTH-1:0] horn_phase_q, horn_phase_d;
	logic                   horn_level_q, horn_level_d;
	logic [COUNT_WIDTH-1:0] link_count_q, link_count_d, link_inc;
	logic                   link_alive_q, link_alive_d;
	logic                   link_stop;
	logic [COUNT_WIDTH-1:0] radar_count_q, radar_count_d, radar_inc;
	logic                   radar_hit, radar_stop;
	tsd_radar_state_t       radar_state_q, radar_state_d;

	// led blinker
	always_comb begin
		led_inc     = led_count_q + CNT_ONE;
		led_count_d = led_count_q;
		led_level_d = led_level_q;
		if (item.tick) begin
			if (CMP_W'(led_inc) > CMP_W'(cfg.blink_period)) begin
				led_count_d = '0;
				led_level_d = ~led_level_q;
			end else begin
				led_count_d = led_inc;
			end
		end
	end

	// horn sequencer, phase resumes at one after a beep ends
	always_comb begin
		horn_remaining_d = horn_remaining_q;
		horn_phase_d     = horn_phase_q;
		horn_level_d     = horn_level_q;
		if (item.tick && (horn_remaining_q != '0)) begin
			priority if (CMP_W'(horn_phase_q) < CMP_W'(cfg.horn_on_ticks)) begin
				horn_level_d = 1'b1;
				horn_phase_d = horn_phase_q + CNT_ONE;
			end else if (CMP_W'(horn_phase_q) < CMP_W'(cfg.horn_period_ticks)) begin
				horn_level_d = 1'b0;
				horn_phase_d = horn_phase_q + CNT_ONE;
			end else begin
				horn_remaining_d = horn_remaining_q - HORN_W'(1);
				horn_phase_d     = CNT_ONE;
			end
		end
		if (item.horn_load) begin
			horn_remaining_d = item.horn_count;
		end
	end

	// host link watchdog, a message wins over the tick work on count and link state
	always_comb begin
		link_inc     = link_count_q + CNT_ONE;
		link_count_d = link_count_q;
		link_alive_d = link_alive_q;
		link_stop    = 1'b0;
		if (item.tick) begin
			if (CMP_W'(link_inc) > CMP_W'(cfg.link_timeout)) begin
				link_count_d = '0;
				link_stop    = link_alive_q;
				link_alive_d = 1'b0;
			end else begin
				link_count_d = link_inc;
			end
		end
		if (item.com_received) begin
			link_alive_d = 1'b1;
			link_count_d = '0;
		end
	end

	// radar debounce: saturating run length of detections
	assign radar_inc = (radar_count_q == CNT_MAX) ? radar_count_q : radar_count_q + CNT_ONE;
	assign radar_hit = CMP_W'(radar_inc) > CMP_W'(cfg.radar_debounce);

	always_comb begin
		radar_state_d = radar_state_q;
		unique case (radar_state_q)
			RADAR_IDLE: begin
				if (item.radar_detected && radar_hit) begin
					radar_state_d = RADAR_STOPPING;
				end
			end
			RADAR_STOPPING: begin
				if (!item.radar_detected) begin
					radar_state_d = RADAR_IDLE;
				end
			end
			default: radar_state_d = RADAR_IDLE;
		endcase
	end

	always_comb begin
		radar_count_d = radar_count_q;
		radar_stop    = 1'b0;
		unique case (radar_state_q)
			RADAR_IDLE: begin
				radar_count_d = item.radar_detected ? radar_inc : '0;
				radar_stop    = item.radar_detected && radar_hit;
			end
			RADAR_STOPPING: begin
				radar_count_d = radar_count_q;
			end
			default: radar_count_d = radar_count_q;
		endcase
	end

	always_comb begin
		result.led          = led_level_d;
		result.horn         = horn_level_d;
		result.stop_request = link_stop | radar_stop;
		result.link_active  = link_alive_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q      <= '0;
			led_level_q      <= 1'b0;
			horn_remaining_q <= '0;
			horn_phase_q     <= '0;
			horn_level_q     <= 1'b0;
			link_count_q     <= '0;
			link_alive_q     <= 1'b0;
			radar_count_q    <= '0;
			radar_state_q    <= RADAR_IDLE;
		end else if (go) begin
			led_count_q      <= led_count_d;
			led_level_q      <= led_level_d;
			horn_remaining_q <= horn_remaining_d;
			horn_phase_q     <= horn_phase_d;
			horn_level_q     <= horn_level_d;
			link_count_q     <= link_count_d;
			link_alive_q     <= link_alive_d;
			radar_count_q    <= radar_count_d;
			radar_state_q    <= radar_state_d;
		end
	end

endmodule

// ===== hdl/tsd_checker.sv =====
// ----------------------------------------------------------------------------
// tsd_checker
// Port-level checks of the tick supervisor, bound to its top level.
// ----------------------------------------------------------------------------
module tsd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           item_stall,
	input logic                           result_valid,
	input logic                           result_stall,
	input tsd_pkg::tsd_out_t              result
);
	import tsd_pkg::*;

	logic prev_alive_q;
	logic result_take;

	assign result_take = result_valid && !result_stall;

	// link state of the last delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_alive_q <= 1'b0;
		end else if (result_take) begin
			prev_alive_q <= result.link_active;
		end
	end

	// a held result stays offered
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// a held result keeps its payload
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result changed while stalled");

	// back pressure on passes only comes from a blocked result
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("pass stalled without a blocked result");

	// a live link only dies through a timeout stop
	a_link_drop_stops: assert property (@(posedge clk) disable iff (!arst_n)
		result_take && prev_alive_q && !result.link_active |-> result.stop_request)
		else $error("link dropped without a stop request");

endmodule

bind tick_supervisor_with_debounce_unit tsd_checker u_tsd_checker (.*);

// ===== tb/tick_supervisor_with_debounce_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tick_supervisor_with_debounce_unit_tb
// Self-checking bench for the main-loop supervisor. A clocked driver feeds
// pass transactions in random bursts and a clocked monitor predicts the led,
// horn, stop and link status of every accepted pass and checks each result
// transaction in order, over several register settings with random stalls.
// ----------------------------------------------------------------------------
module tick_supervisor_with_debounce_unit_tb;
	import tsd_pkg::*;

	localparam int CNT_W       = 8;
	// worst case is far below this, even with heavy stalling on both sides
	localparam int CYCLE_LIMIT = 400000;

	logic                 clk;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_stall;
	tsd_in_t              item;
	logic                 result_valid;
	logic                 result_stall;
	tsd_out_t             result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// pass transactions waiting for the driver, statuses waiting for the monitor
	tsd_in_t  passes_pending[$];
	tsd_out_t status_due[$];

	// register copy used by the status predictor
	tsd_cfg_t cfg_now;

	// predictor state of the supervisor
	logic [CNT_W-1:0]  led_cnt;
	logic              led_lvl;
	logic [HORN_W-1:0] horn_left;
	logic [CNT_W-1:0]  horn_ph;
	logic              horn_lvl;
	logic [CNT_W-1:0]  link_cnt;
	logic              link_up;
	logic [CNT_W-1:0]  radar_cnt;
	tsd_radar_state_t  radar_st;

	// driver and receiver pacing
	bit          pass_taken;
	bit          load_pass;
	bit          drain_hold;
	int          burst_left;
	int          gap_left;
	tsd_in_t     next_pass;
	logic [31:0] stall_bits;
	int          stall_left;

	// radar run shaping for the random passes
	bit radar_hold;
	int radar_run;

	tsd_out_t want;
	int       fails;
	int       cyc_count;

	tick_supervisor_with_debounce_unit #(
		.COUNT_WIDTH (CNT_W)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// status expected after one pass; advances the predictor state
	function automatic tsd_out_t step_supervisor(input tsd_in_t p);
		tsd_out_t o;
		logic     stop;
		stop = 1'b0;
		if (p.tick) begin
			// led blinker: toggles once the count passes the blink period
			led_cnt = led_cnt + 1'b1;
			if (led_cnt > cfg_now.blink_period) begin
				led_cnt = '0;
				led_lvl = ~led_lvl;
			end
			// horn sequencer, phase restarts at one after each finished beep
			if (horn_left != '0) begin
				if (horn_ph < cfg_now.horn_on_ticks) begin
					horn_lvl = 1'b1;
				end else if (horn_ph < cfg_now.horn_period_ticks) begin
					horn_lvl = 1'b0;
				end else begin
					horn_left = horn_left - 1'b1;
					horn_ph   = '0;
				end
				horn_ph = horn_ph + 1'b1;
			end
			// link watchdog: only a live link raises a stop on timeout
			link_cnt = link_cnt + 1'b1;
			if (link_cnt > cfg_now.link_timeout) begin
				if (link_up) begin
					stop    = 1'b1;
					link_up = 1'b0;
				end
				link_cnt = '0;
			end
		end
		// message and horn load act after the tick work
		if (p.com_received) begin
			link_up  = 1'b1;
			link_cnt = '0;
		end
		if (p.horn_load)
			horn_left = p.horn_count;
		// radar debounce, count saturates and survives the return to idle
		if (radar_st == RADAR_IDLE) begin
			if (p.radar_detected) begin
				if (radar_cnt != '1)
					radar_cnt = radar_cnt + 1'b1;
				if (radar_cnt > cfg_now.radar_debounce) begin
					stop     = 1'b1;
					radar_st = RADAR_STOPPING;
				end
			end else begin
				radar_cnt = '0;
			end
		end else if (!p.radar_detected) begin
			radar_st = RADAR_IDLE;
		end
		o.led          = led_lvl;
		o.horn         = horn_lvl;
		o.stop_request = stop;
		o.link_active  = link_up;
		return o;
	endfunction

	function automatic tsd_in_t make_pass(input logic t, input logic r, input logic c,
			input logic l, input logic [HORN_W-1:0] n);
		return tsd_in_t'({t, r, c, l, n});
	endfunction

	// random pass: radar level comes in runs around the debounce length,
	// with some noise on top; horn loads are rare and mostly short
	function automatic tsd_in_t draw_pass(input int tick_pct, input int com_pct);
		tsd_in_t p;
		int      rd;
		rd = int'(cfg_now.radar_debounce);
		if (radar_run == 0) begin
			radar_hold = ~radar_hold;
			if (!radar_hold)
				radar_run = $urandom_range(1, 4);
			else if ($urandom_range(0, 7) == 0)
				radar_run = rd + $urandom_range(1, 4);
			else
				radar_run = $urandom_range(1, (rd < 6) ? rd + 3 : 8);
		end
		radar_run--;
		p.radar_detected = radar_hold;
		if ($urandom_range(0, 9) == 0)
			p.radar_detected = 1'($urandom);
		p.tick         = ($urandom_range(0, 99) < tick_pct);
		p.com_received = ($urandom_range(0, 99) < com_pct);
		p.horn_load    = ($urandom_range(0, 99) < 3);
		p.horn_count   = HORN_W'($urandom);
		if (p.horn_load) begin
			case ($urandom_range(0, 7))
				0:       p.horn_count = '1;
				1:       p.horn_count = '0;
				default: p.horn_count = HORN_W'($urandom_range(1, 3));
			endcase
		end
		return p;
	endfunction

	// register write through the configuration channel
	task automatic write_reg(input tsd_reg_idx_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_BLINK_PERIOD:      cfg_now.blink_period      = val;
			REG_HORN_ON_TICKS:     cfg_now.horn_on_ticks     = val;
			REG_HORN_PERIOD_TICKS: cfg_now.horn_period_ticks = val;
			REG_LINK_TIMEOUT:      cfg_now.link_timeout      = val;
			REG_RADAR_DEBOUNCE:    cfg_now.radar_debounce    = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(input logic [CFG_W-1:0] blink, input logic [CFG_W-1:0] on_t,
			input logic [CFG_W-1:0] per_t, input logic [CFG_W-1:0] link_t,
			input logic [CFG_W-1:0] deb);
		write_reg(REG_BLINK_PERIOD, blink);
		write_reg(REG_HORN_ON_TICKS, on_t);
		write_reg(REG_HORN_PERIOD_TICKS, per_t);
		write_reg(REG_LINK_TIMEOUT, link_t);
		write_reg(REG_RADAR_DEBOUNCE, deb);
	endtask

	// block is idle once nothing is queued, offered or outstanding
	task automatic wait_idle;
		while (passes_pending.size() != 0 || item_valid || status_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input int count, input int tick_pct, input int com_pct);
		for (int i = 0; i < count; i++)
			passes_pending.push_back(draw_pass(tick_pct, com_pct));
		wait_idle();
	endtask

	// pass driver: bursts of random length, random gaps, now and then a hold
	// until every outstanding status has come back
	always @(negedge clk) begin
		if (arst_n && (!item_valid || pass_taken)) begin
			pass_taken = 1'b0;
			load_pass  = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (drain_hold) begin
				drain_hold = (status_due.size() != 0);
			end else if (passes_pending.size() != 0) begin
				next_pass = passes_pending.pop_front();
				load_pass = 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 40);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					drain_hold = ($urandom_range(0, 24) == 0);
				end
			end
			item_valid <= load_pass;
			if (load_pass)
				item <= next_pass;
		end
	end

	// result receiver: rotating stall pattern that is redrawn at random,
	// from no stalls at all up to stalling most of the time
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_left = 48;
			case ($urandom_range(0, 3))
				0:       stall_bits = '0;
				1:       stall_bits = $urandom;
				2:       stall_bits = $urandom & $urandom;
				default: stall_bits = $urandom | $urandom;
			endcase
		end
		stall_left--;
		result_stall <= stall_bits[0];
		stall_bits = {stall_bits[0], stall_bits[31:1]};
	end

	// monitor: predict on every accepted pass, check every accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				status_due.push_back(step_supervisor(item));
				pass_taken = 1'b1;
			end
			if (result_valid && !result_stall) begin
				if (status_due.size() == 0) begin
					$error("result transaction with no pass outstanding");
					fails++;
				end else begin
					want = status_due.pop_front();
					if (result.led !== want.led) begin
						$error("led: expected %0b, actual %0b", want.led, result.led);
						fails++;
					end
					if (result.horn !== want.horn) begin
						$error("horn: expected %0b, actual %0b", want.horn, result.horn);
						fails++;
					end
					if (result.stop_request !== want.stop_request) begin
						$error("stop_request: expected %0b, actual %0b",
							want.stop_request, result.stop_request);
						fails++;
					end
					if (result.link_active !== want.link_active) begin
						$error("link_active: expected %0b, actual %0b",
							want.link_active, result.link_active);
						fails++;
					end
				end
			end
		end
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cyc_count++;
		if (cyc_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		result_stall = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		cfg_now      = '{RST_BLINK_PERIOD, RST_HORN_ON_TICKS, RST_HORN_PERIOD_TICKS,
			RST_LINK_TIMEOUT, RST_RADAR_DEBOUNCE};
		led_cnt      = '0;
		led_lvl      = 1'b0;
		horn_left    = '0;
		horn_ph      = '0;
		horn_lvl     = 1'b0;
		link_cnt     = '0;
		link_up      = 1'b0;
		radar_cnt    = '0;
		radar_st     = RADAR_IDLE;
		pass_taken   = 1'b0;
		drain_hold   = 1'b0;
		burst_left   = 0;
		gap_left     = 0;
		stall_bits   = '0;
		stall_left   = 0;
		radar_hold   = 1'b0;
		radar_run    = 0;
		fails        = 0;
		cyc_count    = 0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed passes on the reset register values
		passes_pending.push_back(make_pass(1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
		// everything at once, longest beep count
		passes_pending.push_back(make_pass(1'b1, 1'b1, 1'b1, 1'b1, 8'hFF));
		// reload while a sequence is running
		passes_pending.push_back(make_pass(1'b1, 1'b1, 1'b0, 1'b1, 8'h02));
		passes_pending.push_back(make_pass(1'b1, 1'b1, 1'b0, 1'b0, 8'h55));
		// fourth detection in a row passes the debounce
		passes_pending.push_back(make_pass(1'b1, 1'b1, 1'b0, 1'b0, 8'hAA));
		passes_pending.push_back(make_pass(1'b1, 1'b1, 1'b0, 1'b0, 8'h00));
		// back to idle with the count kept, sixth tick toggles the led
		passes_pending.push_back(make_pass(1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
		// detection right after the return stops again at once
		passes_pending.push_back(make_pass(1'b0, 1'b1, 1'b0, 1'b0, 8'h00));
		// message without a tick
		passes_pending.push_back(make_pass(1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
		// loading zero beeps halts the horn with its level held
		passes_pending.push_back(make_pass(1'b1, 1'b0, 1'b1, 1'b1, 8'h00));
		for (int i = 0; i < 14; i++)
			passes_pending.push_back(make_pass(1'b1, 1'b0, 1'b0, 1'b0, 8'(i)));
		wait_idle();

		// lowest settings: one detection stops, link times out on the second tick
		set_regs(8'd1, 8'd0, 8'd1, 8'd1, 8'd0);
		run_phase(230, 70, 10);

		// highest settings, no messages so the live link eventually times out
		set_regs(8'd254, 8'd254, 8'd254, 8'd254, 8'd254);
		run_phase(300, 95, 0);

		// reset values written back explicitly
		set_regs(RST_BLINK_PERIOD, RST_HORN_ON_TICKS, RST_HORN_PERIOD_TICKS,
			RST_LINK_TIMEOUT, RST_RADAR_DEBOUNCE);
		run_phase(230, 80, 4);

		// horn on time longer than the period
		set_regs(8'd2, 8'd6, 8'd3, 8'd4, 8'd1);
		run_phase(230, 60, 6);

		// random small settings
		set_regs(8'($urandom_range(1, 12)), 8'($urandom_range(0, 12)),
			8'($urandom_range(1, 12)), 8'($urandom_range(1, 30)),
			8'($urandom_range(0, 8)));
		run_phase(220, $urandom_range(40, 100), $urandom_range(1, 6));

		// random settings over the full range
		set_regs(8'($urandom_range(1, 254)), 8'($urandom_range(0, 254)),
			8'($urandom_range(1, 254)), 8'($urandom_range(1, 254)),
			8'($urandom_range(0, 254)));
		run_phase(220, $urandom_range(40, 100), $urandom_range(1, 6));

		repeat (10) @(posedge clk);
		if (status_due.size() != 0) begin
			$error("%0d status transactions never arrived", status_due.size());
			fails++;
		end
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/tsd_pkg.sv
hdl/tsd_core.sv
hdl/tick_supervisor_with_debounce_unit.sv
hdl/tsd_checker.sv
tb/tick_supervisor_with_debounce_unit_tb.sv
